>>> design/periodic_nearest_source_labeler_defines.svh
// Assertion macros shared by the labeler RTL.
// No dependencies; included by files that carry assertions.
`ifndef PERIODIC_NEAREST_SOURCE_LABELER_DEFINES_SVH
`define PERIODIC_NEAREST_SOURCE_LABELER_DEFINES_SVH

// Same-cycle implication.
`define PNSL_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define PNSL_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/pnsl_pkg.sv
// Package for the periodic nearest-source labeler: widths, codes, reset table.
// No dependencies; used by pnsl_cell and periodic_nearest_source_labeler.
package pnsl_pkg;

	localparam int SIDE_W     = 8;
	localparam int ACTIVE_W   = 4;
	localparam int SLOT_W     = 3;
	localparam int DIST_OUT_W = 14;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;

	localparam int DIST_SAT = 16383;

	localparam int DEF_MAX_SOURCES = 8;
	localparam int DEF_COORD_WIDTH = 7;

	localparam logic [SIDE_W-1:0]   SIDE_RESET   = 8'd101;
	localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 4'd2;

	localparam int SRC0_X = 30;
	localparam int SRC0_Y = 50;
	localparam int SRC0_Z = 50;
	localparam int SRC1_X = 70;
	localparam int SRC1_Y = 50;
	localparam int SRC1_Z = 50;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_TORUS_SIDE     = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_SOURCES = 1'd1;

	// Control word that moves down the cell chain with each item.
	typedef struct packed {
		logic              valid;
		logic              query;
		logic              load;
		logic              err;
		logic [SLOT_W-1:0] slot;
	} ctl_t;

endpackage

>>> design/pnsl_cell.sv
// One cell of the labeler chain: holds one source slot, folds and squares the
// axis distances, then updates the running nearest. Depends on pnsl_pkg.
module pnsl_cell #(
	parameter int COORD_WIDTH = pnsl_pkg::DEF_COORD_WIDTH,
	parameter int INDEX       = 0,
	parameter int DW          = 20,
	parameter int SIDX_W      = 3
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic [pnsl_pkg::SIDE_W-1:0]         side,
	input  logic [pnsl_pkg::ACTIVE_W-1:0]       active,
	input  pnsl_pkg::ctl_t                      ctl_in,
	input  logic [2:0][COORD_WIDTH-1:0]         crd_in,
	input  logic [DW-1:0]                       best_in,
	input  logic [SIDX_W-1:0]                   bslot_in,
	output pnsl_pkg::ctl_t                      ctl_out,
	output logic [2:0][COORD_WIDTH-1:0]         crd_out,
	output logic [DW-1:0]                       best_out,
	output logic [SIDX_W-1:0]                   bslot_out
);

	localparam int AW = ((COORD_WIDTH > pnsl_pkg::SIDE_W) ? COORD_WIDTH : pnsl_pkg::SIDE_W) + 1;
	localparam int W  = AW + 1;

	localparam logic [2:0][COORD_WIDTH-1:0] RST_SRC =
		(INDEX == 0) ? {COORD_WIDTH'(pnsl_pkg::SRC0_Z), COORD_WIDTH'(pnsl_pkg::SRC0_Y),
			COORD_WIDTH'(pnsl_pkg::SRC0_X)} :
		(INDEX == 1) ? {COORD_WIDTH'(pnsl_pkg::SRC1_Z), COORD_WIDTH'(pnsl_pkg::SRC1_Y),
			COORD_WIDTH'(pnsl_pkg::SRC1_X)} : '0;

	logic [2:0][COORD_WIDTH-1:0] src_q;
	logic                        wr_hit;
	logic                        take;

	logic signed [W-1:0] sd;
	logic signed [W-1:0] hs;
	logic signed [W-1:0] d    [3];
	logic [AW-1:0]       mag  [3];
	logic [2*AW-1:0]     sq   [3];

	pnsl_pkg::ctl_t              ctl_s1;
	logic [2:0][COORD_WIDTH-1:0] crd_s1;
	logic [DW-1:0]               best_s1;
	logic [SIDX_W-1:0]           bslot_s1;
	logic [2*AW-1:0]             sq_s1 [3];

	logic [DW-1:0]               r2;
	logic                        upd;

	pnsl_pkg::ctl_t              ctl_s2;
	logic [2:0][COORD_WIDTH-1:0] crd_s2;
	logic [DW-1:0]               best_s2;
	logic [SIDX_W-1:0]           bslot_s2;

	assign wr_hit = en && ctl_in.valid && ctl_in.load && (32'(ctl_in.slot) == 32'(INDEX));
	assign take   = (INDEX == 0) || (32'(active) > 32'(INDEX));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_q <= RST_SRC;
		end else if (wr_hit) begin
			src_q <= crd_in;
		end
	end

	// Periodic fold of each axis difference, then square.
	always_comb begin
		sd = signed'(W'(side));
		hs = signed'(W'(side >> 1));
		for (int a = 0; a < 3; a++) begin
			d[a] = signed'(W'(crd_in[a])) - signed'(W'(src_q[a]));
			if (d[a] > hs) begin
				d[a] = d[a] - sd;
			end else if (d[a] < -hs) begin
				d[a] = d[a] + sd;
			end
			mag[a] = d[a][W-1] ? AW'(-d[a]) : AW'(d[a]);
			sq[a]  = mag[a] * mag[a];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			crd_s1   <= crd_in;
			best_s1  <= best_in;
			bslot_s1 <= bslot_in;
			for (int a = 0; a < 3; a++) begin
				sq_s1[a] <= sq[a];
			end
		end
	end

	// Strict compare keeps the lowest slot on ties.
	always_comb begin
		r2  = DW'(sq_s1[0]) + DW'(sq_s1[1]) + DW'(sq_s1[2]);
		upd = ctl_s1.query && !ctl_s1.err && take && ((INDEX == 0) || (r2 < best_s1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			crd_s2   <= crd_s1;
			best_s2  <= upd ? r2 : best_s1;
			bslot_s2 <= upd ? SIDX_W'(INDEX) : bslot_s1;
		end
	end

	assign ctl_out   = ctl_s2;
	assign crd_out   = crd_s2;
	assign best_out  = best_s2;
	assign bslot_out = bslot_s2;

endmodule

>>> design/periodic_nearest_source_labeler.sv
// Periodic nearest-source labeler top level: config registers, entry check,
// cell chain and output register. Depends on pnsl_pkg, pnsl_cell and the defines header.
//
// Use:
//   Input channel (in_valid/in_ready) carries loads (operation 0) and voxel
//   queries (operation 1). An in-range load writes one source slot and gives no result;
//   a query gives one result on the output channel (out_valid/out_ready).
//   The item walks a chain of MAX_SOURCES cells, one cell per source slot,
//   two register stages per cell, then an output register.
//   Throughput: one item per cycle while the chain does not stall.
//   Loads travel the same chain, so every query sees all earlier loads.
//   Stall: when the output register is full and out_ready is low, the whole
//   chain holds and in_ready drops in the same cycle.
//   Reset: chain empty, torus_side 101, active_sources 2, slot 0 at
//   (30,50,50), slot 1 at (70,50,50), other slots at the origin.
//   The user must write configuration (cfg_we, cfg_index, cfg_data) only while idle; the block does not enforce this.
//
`include "periodic_nearest_source_labeler_defines.svh"

module periodic_nearest_source_labeler #(
	parameter int MAX_SOURCES = pnsl_pkg::DEF_MAX_SOURCES,
	parameter int COORD_WIDTH = pnsl_pkg::DEF_COORD_WIDTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [pnsl_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pnsl_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                operation,
	input  logic [pnsl_pkg::SLOT_W-1:0]         slot,
	input  logic [COORD_WIDTH-1:0]              coord_x,
	input  logic [COORD_WIDTH-1:0]              coord_y,
	input  logic [COORD_WIDTH-1:0]              coord_z,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [pnsl_pkg::DIST_OUT_W-1:0]     nearest_dist_sq,
	output logic [pnsl_pkg::SLOT_W-1:0]         nearest_slot,
	output logic                                coord_error
);

	localparam int AW     = ((COORD_WIDTH > pnsl_pkg::SIDE_W) ? COORD_WIDTH : pnsl_pkg::SIDE_W) + 1;
	localparam int DW     = 2 * AW + 2;
	localparam int CMP_W  = (COORD_WIDTH > pnsl_pkg::SIDE_W) ? COORD_WIDTH : pnsl_pkg::SIDE_W;
	localparam int SIDX_W = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;

	logic [pnsl_pkg::SIDE_W-1:0]   side_q;
	logic [pnsl_pkg::ACTIVE_W-1:0] active_q;

	logic                          en;
	logic                          bad;
	pnsl_pkg::ctl_t                ctl_c   [MAX_SOURCES+1];
	logic [2:0][COORD_WIDTH-1:0]   crd_c   [MAX_SOURCES+1];
	logic [DW-1:0]                 best_c  [MAX_SOURCES+1];
	logic [SIDX_W-1:0]             bslot_c [MAX_SOURCES+1];

	logic                          last_query;
	logic                          out_valid_q;
	logic [pnsl_pkg::DIST_OUT_W-1:0] dist_q;
	logic [pnsl_pkg::SLOT_W-1:0]   slot_q;
	logic                          err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q   <= pnsl_pkg::SIDE_RESET;
			active_q <= pnsl_pkg::ACTIVE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pnsl_pkg::REG_TORUS_SIDE: begin
					side_q <= pnsl_pkg::SIDE_W'(cfg_data);
				end
				pnsl_pkg::REG_ACTIVE_SOURCES: begin
					active_q <= pnsl_pkg::ACTIVE_W'(cfg_data);
				end
				default: begin
				end
			endcase
		end
	end

	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;

	always_comb begin
		bad = (CMP_W'(coord_x) >= CMP_W'(side_q)) ||
			(CMP_W'(coord_y) >= CMP_W'(side_q)) ||
			(CMP_W'(coord_z) >= CMP_W'(side_q));
		ctl_c[0].valid = in_valid;
		ctl_c[0].query = (operation == pnsl_pkg::OP_QUERY);
		ctl_c[0].load  = (operation == pnsl_pkg::OP_LOAD) && !bad;
		ctl_c[0].err   = (operation == pnsl_pkg::OP_QUERY) && bad;
		ctl_c[0].slot  = slot;
		crd_c[0]       = {coord_z, coord_y, coord_x};
		best_c[0]      = '0;
		bslot_c[0]     = '0;
	end

	for (genvar i = 0; i < MAX_SOURCES; i++) begin : g_cell
		pnsl_cell #(
			.COORD_WIDTH (COORD_WIDTH),
			.INDEX       (i),
			.DW          (DW),
			.SIDX_W      (SIDX_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.side      (side_q),
			.active    (active_q),
			.ctl_in    (ctl_c[i]),
			.crd_in    (crd_c[i]),
			.best_in   (best_c[i]),
			.bslot_in  (bslot_c[i]),
			.ctl_out   (ctl_c[i+1]),
			.crd_out   (crd_c[i+1]),
			.best_out  (best_c[i+1]),
			.bslot_out (bslot_c[i+1])
		);
	end

	assign last_query = ctl_c[MAX_SOURCES].valid && ctl_c[MAX_SOURCES].query;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= last_query;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			err_q <= ctl_c[MAX_SOURCES].err;
			if (ctl_c[MAX_SOURCES].err) begin
				dist_q <= '0;
				slot_q <= '0;
			end else begin
				dist_q <= (best_c[MAX_SOURCES] > DW'(pnsl_pkg::DIST_SAT)) ?
					pnsl_pkg::DIST_OUT_W'(pnsl_pkg::DIST_SAT) :
					pnsl_pkg::DIST_OUT_W'(best_c[MAX_SOURCES]);
				slot_q <= pnsl_pkg::SLOT_W'(bslot_c[MAX_SOURCES]);
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign nearest_dist_sq = dist_q;
	assign nearest_slot    = slot_q;
	assign coord_error     = err_q;

	`PNSL_ASSERT_NEXT(a_query_reaches_out, clk, arst_n, en && last_query, out_valid_q, "query lost at output register")
	`PNSL_ASSERT_NEXT(a_load_no_result, clk, arst_n, en && !last_query, !out_valid_q, "result without a query")
	`PNSL_ASSERT_IMPL(a_err_zero_fields, clk, arst_n, out_valid_q && err_q, (dist_q == '0) && (slot_q == '0), "error result with nonzero fields")

endmodule
